// ----- hw/rtl/c2p_pkg.sv -----
package c2p_pkg;

   // Fraction bits of the internal angle and rotation datapath
   localparam int WORK_FRAC   = 28;
   localparam int DEG_HALF    = 180;
   localparam int DEG_QUARTER = 90;

   // pi with 56 fraction bits, and cut to the working fraction
   localparam logic [63:0] PI_Q56 = 64'h0324_3F6A_8885_A308;
   localparam logic [63:0] PI_Q28 = PI_Q56 >> (56 - WORK_FRAC);

   // Quadrant codes
   localparam logic [2:0] QUAD_AXIS   = 3'd0;
   localparam logic [2:0] QUAD_FIRST  = 3'd1;
   localparam logic [2:0] QUAD_SECOND = 3'd2;
   localparam logic [2:0] QUAD_THIRD  = 3'd3;
   localparam logic [2:0] QUAD_FOURTH = 3'd4;

   // Control word that travels down the pipeline with each point
   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
      logic zero_x;
      logic zero_y;
   } c2p_ctl_type;

   // v / (2k+1) for the terms of the arctangent series
   function automatic logic [63:0] odd_div(input logic [63:0] v, input int unsigned k);
      logic [63:0] q;
      q = v;
      unique case (k)
         0:  q = v;
         1:  q = v / 64'd3;
         2:  q = v / 64'd5;
         3:  q = v / 64'd7;
         4:  q = v / 64'd9;
         5:  q = v / 64'd11;
         6:  q = v / 64'd13;
         7:  q = v / 64'd15;
         8:  q = v / 64'd17;
         9:  q = v / 64'd19;
         10: q = v / 64'd21;
         11: q = v / 64'd23;
         12: q = v / 64'd25;
         13: q = v / 64'd27;
         14: q = v / 64'd29;
         15: q = v / 64'd31;
         16: q = v / 64'd33;
         17: q = v / 64'd35;
         18: q = v / 64'd37;
         19: q = v / 64'd39;
         20: q = v / 64'd41;
         21: q = v / 64'd43;
         22: q = v / 64'd45;
         23: q = v / 64'd47;
         24: q = v / 64'd49;
         25: q = v / 64'd51;
         26: q = v / 64'd53;
         27: q = v / 64'd55;
         default: q = v;
      endcase
      return q;
   endfunction

   // atan(2^-idx) in degrees with WORK_FRAC fraction bits
   function automatic logic [63:0] atan_deg(input int unsigned idx);
      logic [63:0]  acc;
      logic [63:0]  term;
      int unsigned  e;
      acc  = '0;
      term = '0;
      e    = 0;
      if (idx == 0) begin
         return 64'd45 << WORK_FRAC;
      end
      for (int unsigned k = 0; k < 28; k++) begin
         e = idx * (2 * k + 1);
         if (e <= 56) begin
            term = odd_div(64'd1 << (56 - e), k);
            if (k[0]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
      end
      return (acc * 64'd180) / PI_Q28;
   endfunction

endpackage

// ----- hw/rtl/c2p_cell.sv -----
module c2p_cell import c2p_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int ITERATIONS  = 18,
   parameter int STAGE       = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  c2p_ctl_type                             up_ctl,
   input  logic signed [COORD_WIDTH+WORK_FRAC+1:0] up_x,
   input  logic signed [COORD_WIDTH+WORK_FRAC+1:0] up_y,
   input  logic signed [WORK_FRAC+7:0]             up_z,
   input  logic        [2*COORD_WIDTH-1:0]         up_n,
   input  logic        [COORD_WIDTH+1:0]           up_rem,
   input  logic        [COORD_WIDTH-1:0]           up_root,
   output c2p_ctl_type                             dn_ctl,
   output logic signed [COORD_WIDTH+WORK_FRAC+1:0] dn_x,
   output logic signed [COORD_WIDTH+WORK_FRAC+1:0] dn_y,
   output logic signed [WORK_FRAC+7:0]             dn_z,
   output logic        [2*COORD_WIDTH-1:0]         dn_n,
   output logic        [COORD_WIDTH+1:0]           dn_rem,
   output logic        [COORD_WIDTH-1:0]           dn_root
);

   localparam int W  = COORD_WIDTH + WORK_FRAC + 2;
   localparam int ZW = WORK_FRAC + 8;
   localparam int SW = COORD_WIDTH + 2;
   localparam int NW = 2 * COORD_WIDTH;

   c2p_ctl_type           ctl_ff;
   logic signed [W-1:0]   x_in, x_ff;
   logic signed [W-1:0]   y_in, y_ff;
   logic signed [ZW-1:0]  z_in, z_ff;
   logic [NW-1:0]         n_in, n_ff;
   logic [SW-1:0]         rem_in, rem_ff;
   logic [COORD_WIDTH-1:0] root_in, root_ff;

   // One micro-rotation, driven toward y = 0
   if (STAGE < ITERATIONS) begin : g_rot
      localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(atan_deg(STAGE));
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;
      always_comb begin
         dx = up_y >>> STAGE;
         dy = up_x >>> STAGE;
         if (!up_y[W-1]) begin
            x_in = up_x + dx;
            y_in = up_y - dy;
            z_in = up_z + ATAN_STEP;
         end else begin
            x_in = up_x - dx;
            y_in = up_y + dy;
            z_in = up_z - ATAN_STEP;
         end
      end
   end else begin : g_rot_hold
      assign x_in = up_x;
      assign y_in = up_y;
      assign z_in = up_z;
   end

   // One root digit: bring down two bits, try root*4+1
   if (STAGE < COORD_WIDTH) begin : g_root
      logic [SW-1:0] shifted;
      logic [SW-1:0] trial;
      always_comb begin
         shifted = {up_rem[SW-3:0], up_n[NW-1 -: 2]};
         trial   = {up_root, 2'b01};
         n_in    = {up_n[NW-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {up_root[COORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {up_root[COORD_WIDTH-2:0], 1'b0};
         end
      end
   end else begin : g_root_hold
      assign n_in    = up_n;
      assign rem_in  = up_rem;
      assign root_in = up_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         n_ff    <= n_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_z    = z_ff;
   assign dn_n    = n_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;

endmodule

// ----- hw/rtl/cartesian_to_polar_with_quadrant.sv -----
// Path: an accepted req beat passes the stage 1, 2 and 3 registers, the cell chain and
//       the output register before rsp_tvalid rises.
// Throughput: one beat per cycle while the skid register is empty; a cell does at most one
//             CORDIC micro-rotation and one root digit and takes a new point on each advance.
// Reset: synchronous, active high; clears all valid flags, the pipeline comes up empty.
module cartesian_to_polar_with_quadrant import c2p_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8,
   parameter int ITERATIONS  = 18
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_tvalid,
   output logic                                               req_tready,
   // req_tdata, from bit 0 up: x_coord, y_coord, zero pad
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]                 req_tdata,
   output logic                                               rsp_tvalid,
   input  logic                                               rsp_tready,
   // rsp_tdata, from bit 0 up: quadrant (3), radius, angle_degrees, zero pad
   output logic [((3+COORD_WIDTH+FRAC_BITS+9+7)/8)*8-1:0]     rsp_tdata
);

   localparam int N        = (ITERATIONS > COORD_WIDTH) ? ITERATIONS : COORD_WIDTH;
   localparam int W        = COORD_WIDTH + WORK_FRAC + 2;
   localparam int ZW       = WORK_FRAC + 8;
   localparam int SW       = COORD_WIDTH + 2;
   localparam int NW       = 2 * COORD_WIDTH;
   localparam int AW       = FRAC_BITS + 9;
   localparam int RSP_W    = ((3 + COORD_WIDTH + AW + 7) / 8) * 8;
   localparam int RND_SHIFT = WORK_FRAC - FRAC_BITS;

   localparam logic [ZW-2:0] Z_TOP       = (ZW-1)'(DEG_QUARTER) << WORK_FRAC;
   localparam logic [ZW-2:0] Z_HALF_LSB  = (ZW-1)'(1) << (RND_SHIFT - 1);
   localparam logic signed [AW-1:0] ANG_HALF    = AW'(DEG_HALF) << FRAC_BITS;
   localparam logic signed [AW-1:0] ANG_QUARTER = AW'(DEG_QUARTER) << FRAC_BITS;
   localparam logic signed [AW-1:0] ANG_LOW     = AW'(1) - ANG_HALF;

   // The whole pipeline moves together; it only stops while the skid register holds a beat
   logic advance;
   logic skid_valid_ff, skid_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   // Stage 1: split the beat, take magnitudes and signs
   logic [COORD_WIDTH-1:0] req_x, req_y;
   c2p_ctl_type            ctl1_in, ctl1_ff;
   logic [COORD_WIDTH-1:0] ax1_in, ax1_ff, ay1_in, ay1_ff;

   assign req_x = req_tdata[COORD_WIDTH-1:0];
   assign req_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

   always_comb begin
      ctl1_in.valid  = req_tvalid;
      ctl1_in.neg_x  = req_x[COORD_WIDTH-1];
      ctl1_in.neg_y  = req_y[COORD_WIDTH-1];
      ctl1_in.zero_x = (req_x == '0);
      ctl1_in.zero_y = (req_y == '0);
      // two's complement negate; the most negative code maps to 2^(COORD_WIDTH-1) unsigned
      ax1_in = req_x[COORD_WIDTH-1] ? (~req_x + 1'b1) : req_x;
      ay1_in = req_y[COORD_WIDTH-1] ? (~req_y + 1'b1) : req_y;
   end

   // Stage 2: squares for the radius, magnitudes held for the rotation
   c2p_ctl_type            ctl2_ff;
   logic [NW-1:0]          sq_x_in, sq_x_ff, sq_y_in, sq_y_ff;
   logic [COORD_WIDTH-1:0] ax2_ff, ay2_ff;

   assign sq_x_in = NW'(ax1_ff) * NW'(ax1_ff);
   assign sq_y_in = NW'(ay1_ff) * NW'(ay1_ff);

   // Stage 3: sum of squares and the scaled start vector
   c2p_ctl_type         ctl3_ff;
   logic [NW-1:0]       n3_in, n3_ff;
   logic signed [W-1:0] x3_in, x3_ff, y3_in, y3_ff;

   assign n3_in = sq_x_ff + sq_y_ff;
   assign x3_in = signed'({2'b00, ax2_ff, {WORK_FRAC{1'b0}}});
   assign y3_in = signed'({2'b00, ay2_ff, {WORK_FRAC{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax1_ff  <= ax1_in;
         ay1_ff  <= ay1_in;
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         n3_ff   <= n3_in;
         x3_ff   <= x3_in;
         y3_ff   <= y3_in;
      end
   end

   // Cell chain: slot 0 is fed by stage 3, slot N is the last cell's output
   c2p_ctl_type            chain_ctl  [0:N];
   logic signed [W-1:0]    chain_x    [0:N];
   logic signed [W-1:0]    chain_y    [0:N];
   logic signed [ZW-1:0]   chain_z    [0:N];
   logic [NW-1:0]          chain_n    [0:N];
   logic [SW-1:0]          chain_rem  [0:N];
   logic [COORD_WIDTH-1:0] chain_root [0:N];

   assign chain_ctl[0]  = ctl3_ff;
   assign chain_x[0]    = x3_ff;
   assign chain_y[0]    = y3_ff;
   assign chain_z[0]    = '0;
   assign chain_n[0]    = n3_ff;
   assign chain_rem[0]  = '0;
   assign chain_root[0] = '0;

   for (genvar g = 0; g < N; g++) begin : g_cell
      c2p_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .ITERATIONS  (ITERATIONS),
         .STAGE       (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctl  (chain_ctl[g]),
         .up_x    (chain_x[g]),
         .up_y    (chain_y[g]),
         .up_z    (chain_z[g]),
         .up_n    (chain_n[g]),
         .up_rem  (chain_rem[g]),
         .up_root (chain_root[g]),
         .dn_ctl  (chain_ctl[g+1]),
         .dn_x    (chain_x[g+1]),
         .dn_y    (chain_y[g+1]),
         .dn_z    (chain_z[g+1]),
         .dn_n    (chain_n[g+1]),
         .dn_rem  (chain_rem[g+1]),
         .dn_root (chain_root[g+1])
      );
   end

   // Finish: round the root, clamp and round the angle, fold it into its quadrant
   c2p_ctl_type            last_ctl;
   logic [ZW-2:0]          z_clamp, z_round;
   logic signed [AW-1:0]   theta, fin_angle;
   logic [COORD_WIDTH-1:0] fin_radius;
   logic [2:0]             fin_quad;
   logic [RSP_W-1:0]       fin_beat;

   assign last_ctl = chain_ctl[N];

   always_comb begin
      priority if (chain_z[N][ZW-1]) begin
         z_clamp = '0;
      end else if (chain_z[N][ZW-2:0] > Z_TOP) begin
         z_clamp = Z_TOP;
      end else begin
         z_clamp = chain_z[N][ZW-2:0];
      end
      z_round = z_clamp + Z_HALF_LSB;
      theta   = AW'(z_round >> RND_SHIFT);

      // round to nearest: step up when the remainder exceeds the floor root
      fin_radius = chain_root[N] + COORD_WIDTH'(chain_rem[N] > SW'(chain_root[N]));

      priority if (last_ctl.zero_x || last_ctl.zero_y) begin
         fin_quad = QUAD_AXIS;
      end else if (!last_ctl.neg_x) begin
         fin_quad = last_ctl.neg_y ? QUAD_FOURTH : QUAD_FIRST;
      end else begin
         fin_quad = last_ctl.neg_y ? QUAD_THIRD : QUAD_SECOND;
      end

      priority if (last_ctl.zero_x && last_ctl.zero_y) begin
         fin_angle = '0;
      end else if (last_ctl.zero_x) begin
         fin_angle = last_ctl.neg_y ? -ANG_QUARTER : ANG_QUARTER;
      end else if (last_ctl.zero_y) begin
         fin_angle = last_ctl.neg_x ? ANG_HALF : '0;
      end else if (!last_ctl.neg_x) begin
         fin_angle = last_ctl.neg_y ? -theta : theta;
      end else if (!last_ctl.neg_y) begin
         fin_angle = ANG_HALF - theta;
      end else if (theta == '0) begin
         // just below the negative x axis: keep the angle inside (-180, 180]
         fin_angle = ANG_LOW;
      end else begin
         fin_angle = theta - ANG_HALF;
      end

      fin_beat = RSP_W'({fin_angle, fin_radius, fin_quad});
   end

   // Output register plus skid register: a finished beat always has a place to land
   logic             out_take;
   logic             load_out_fin, load_out_skid, load_skid;
   logic [RSP_W-1:0] rsp_data_ff, skid_data_ff;

   assign out_take = rsp_valid_ff && rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out_fin  = 1'b0;
      load_out_skid = 1'b0;
      load_skid     = 1'b0;
      priority if (skid_valid_ff) begin
         // drain the skid beat into the output as soon as the output is taken
         if (out_take) begin
            load_out_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (last_ctl.valid) begin
         if (!rsp_valid_ff || out_take) begin
            load_out_fin = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_skid) begin
         rsp_data_ff <= skid_data_ff;
      end else if (load_out_fin) begin
         rsp_data_ff <= fin_beat;
      end
      if (load_skid) begin
         skid_data_ff <= fin_beat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
